// File: design/fita_pkg.sv
// ----------------------------------------------------------------------------
// fita_pkg: shared types and constants of the file entry table allocator
// Operation and status codes, default sizes and bitmap word helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package fita_pkg;

  localparam int unsigned NUM_ENTRIES_DEF = 16;
  localparam int unsigned NUM_BLOCKS_DEF  = 512;

  // free-block bitmap is kept as words of this many bits
  localparam int unsigned MAP_WORD_W = 32;
  localparam int unsigned MAP_BIT_W  = 5;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned ID_W     = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned BLOCK_W  = 9;

  // blocks below this number are taken at format time
  localparam int unsigned FIRST_FREE_BLOCK = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_CREATE = 2'd1,
    MODE_DELETE = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_NO_ENTRY  = 3'd3,
    ST_NO_BLOCK  = 3'd4
  } status_t;

  // position of the lowest set bit of a bitmap word (0 for an empty word)
  function automatic logic [MAP_BIT_W-1:0] lowest_set(input logic [MAP_WORD_W-1:0] w);
    logic [MAP_BIT_W-1:0] pos;
    pos = '0;
    for (int i = MAP_WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        pos = MAP_BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

// File: design/file_inode_table_allocator_unit.sv
// ----------------------------------------------------------------------------
// file_inode_table_allocator_unit: file entry table with free-block bitmap
// Lookup, create and delete of file entries, allocating and returning blocks.
// ----------------------------------------------------------------------------
// One request at a time. Every lookup, create or delete request scans the
// entry table, one entry a cycle from the entry RAM, and a delete then passes
// through one more state; a create that finds room then walks the bitmap RAM
// one 32-bit word a cycle until it meets a free block. The next request is
// taken while a result still waits on the response side. After reset the
// block writes the formatted bitmap, one word a cycle, before it takes its
// first request. An unused mode is answered not found without a scan.
// entry_index and disk_block carry the low bits of wider indexes.
// ----------------------------------------------------------------------------
`default_nettype none

module file_inode_table_allocator_unit #(
  parameter int unsigned NUM_ENTRIES = fita_pkg::NUM_ENTRIES_DEF,
  parameter int unsigned NUM_BLOCKS  = fita_pkg::NUM_BLOCKS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 req_valid,
  output logic                                      req_ready,
  input  wire logic        [fita_pkg::MODE_W-1:0]   mode,
  input  wire logic signed [fita_pkg::ID_W-1:0]     file_id,
  output logic                                      rsp_valid,
  input  wire logic                                 rsp_ready,
  output logic             [fita_pkg::STATUS_W-1:0] status,
  output logic             [fita_pkg::INDEX_W-1:0]  entry_index,
  output logic             [fita_pkg::BLOCK_W-1:0]  disk_block
);

  localparam int unsigned IW    = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int unsigned BW    = $clog2(NUM_BLOCKS);
  localparam int unsigned WORDS = (NUM_BLOCKS + fita_pkg::MAP_WORD_W - 1) /
                                  fita_pkg::MAP_WORD_W;
  localparam int unsigned WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned XW    = WW + fita_pkg::MAP_BIT_W;
  localparam int unsigned EW    = fita_pkg::ID_W + BW;
  localparam int unsigned MW    = fita_pkg::MAP_WORD_W;
  localparam int unsigned SW    = fita_pkg::STATUS_W;

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_DEL   = 6'b001000,
    S_BSCAN = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t                    state;
  logic [fita_pkg::MODE_W-1:0] op;
  logic [fita_pkg::ID_W-1:0] id;
  logic [NUM_ENTRIES-1:0]    valid;
  logic [IW-1:0]             scan_cnt;
  logic [IW-1:0]             chk_idx;
  logic                      chk_vld;
  logic                      chk_ent_v;
  logic                      free_found;
  logic [IW-1:0]             free_idx;
  logic [IW-1:0]             ent_idx;
  logic [BW-1:0]             blk;
  logic [WW-1:0]             w_cnt;
  logic [WW-1:0]             chk_w;
  logic [WW-1:0]             init_cnt;
  logic [SW-1:0]             res_status;
  logic [IW-1:0]             res_idx;
  logic [BW-1:0]             res_blk;

  // entry RAM: {file id, block}
  logic          ent_we;
  logic [EW-1:0] ent_wdata;
  logic [EW-1:0] ent_rdata;
  logic [fita_pkg::ID_W-1:0] rd_id;
  logic [BW-1:0] rd_blk;

  // bitmap RAM
  logic          bm_we;
  logic [WW-1:0] bm_waddr;
  logic [MW-1:0] bm_wdata;
  logic [WW-1:0] bm_raddr;
  logic [MW-1:0] bm_rdata;

  logic                          hit;
  logic                          last_ent;
  logic                          last_word;
  logic                          word_free;
  logic [fita_pkg::MAP_BIT_W-1:0] free_bit;
  logic [XW-1:0]                 found_x;
  logic [BW-1:0]                 new_blk;
  logic [XW-1:0]                 rd_blk_x;
  logic [XW-1:0]                 blk_x;
  logic [MW-1:0]                 init_word;
  logic [IW+fita_pkg::INDEX_W-1:0] idx_wide;
  logic [BW+fita_pkg::BLOCK_W-1:0] blk_wide;

  assign rd_id  = ent_rdata[EW-1:BW];
  assign rd_blk = ent_rdata[BW-1:0];

  assign hit       = chk_vld && chk_ent_v && (rd_id == id);
  assign last_ent  = (chk_idx == IW'(NUM_ENTRIES - 1));
  assign last_word = (chk_w == WW'(WORDS - 1));
  assign word_free = (bm_rdata != '0);
  assign free_bit  = fita_pkg::lowest_set(bm_rdata);
  assign found_x   = {chk_w, free_bit};
  assign new_blk   = found_x[BW-1:0];
  assign rd_blk_x  = XW'(rd_blk);
  assign blk_x     = XW'(blk);

  // formatted bitmap word: free where the block exists and is not reserved
  always_comb begin
    logic [XW:0] b;
    init_word = '0;
    for (int j = 0; j < MW; j++) begin
      b = {1'b0, init_cnt, fita_pkg::MAP_BIT_W'(j)};
      init_word[j] = (b >= (XW + 1)'(fita_pkg::FIRST_FREE_BLOCK)) &&
                     (b < (XW + 1)'(NUM_BLOCKS));
    end
  end

  assign ent_we    = (state == S_BSCAN) && chk_vld && word_free;
  assign ent_wdata = {id, new_blk};

  always_comb begin
    bm_we    = 1'b0;
    bm_waddr = init_cnt;
    bm_wdata = init_word;
    // fetch the deleted entry's word as soon as the match shows
    bm_raddr = (state == S_SCAN) ? rd_blk_x[XW-1:fita_pkg::MAP_BIT_W] : w_cnt;
    case (state)
      S_INIT: begin
        bm_we = 1'b1;
      end
      S_DEL: begin
        bm_we    = 1'b1;
        bm_waddr = blk_x[XW-1:fita_pkg::MAP_BIT_W];
        bm_wdata = bm_rdata | (MW'(1) << blk_x[fita_pkg::MAP_BIT_W-1:0]);
      end
      S_BSCAN: begin
        bm_we    = chk_vld && word_free;
        bm_waddr = chk_w;
        bm_wdata = bm_rdata & ~(MW'(1) << free_bit);
      end
      default: begin
        bm_we = 1'b0;
      end
    endcase
  end

  fita_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_idx),
    .wdata (ent_wdata),
    .raddr (scan_cnt),
    .rdata (ent_rdata)
  );

  fita_ram #(
    .WIDTH (MW),
    .DEPTH (WORDS)
  ) u_map_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  assign req_ready = (state == S_IDLE);

  assign idx_wide = (IW + fita_pkg::INDEX_W)'(res_idx);
  assign blk_wide = (BW + fita_pkg::BLOCK_W)'(res_blk);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      init_cnt   <= '0;
      valid      <= '0;
      chk_vld    <= 1'b0;
      free_found <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          if (init_cnt == WW'(WORDS - 1)) begin
            state <= S_IDLE;
          end else begin
            init_cnt <= init_cnt + WW'(1);
          end
        end

        S_IDLE: begin
          if (req_valid) begin
            op         <= mode;
            id         <= file_id;
            scan_cnt   <= '0;
            chk_vld    <= 1'b0;
            free_found <= 1'b0;
            if (mode == fita_pkg::MODE_LOOKUP || mode == fita_pkg::MODE_CREATE ||
                mode == fita_pkg::MODE_DELETE) begin
              state <= S_SCAN;
            end else begin
              // unused mode: answer not found, touch nothing
              res_status <= fita_pkg::ST_NOT_FOUND;
              res_idx    <= '0;
              res_blk    <= '0;
              state      <= S_DONE;
            end
          end
        end

        S_SCAN: begin
          chk_vld   <= 1'b1;
          chk_idx   <= scan_cnt;
          chk_ent_v <= valid[scan_cnt];
          if (scan_cnt != IW'(NUM_ENTRIES - 1)) begin
            scan_cnt <= scan_cnt + IW'(1);
          end
          if (chk_vld) begin
            if (!chk_ent_v && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= chk_idx;
            end
            if (hit) begin
              res_idx <= '0;
              res_blk <= '0;
              case (op)
                fita_pkg::MODE_LOOKUP: begin
                  res_status <= fita_pkg::ST_OK;
                  res_idx    <= chk_idx;
                  res_blk    <= rd_blk;
                  state      <= S_DONE;
                end
                fita_pkg::MODE_CREATE: begin
                  res_status <= fita_pkg::ST_EXISTS;
                  state      <= S_DONE;
                end
                default: begin
                  valid[chk_idx] <= 1'b0;
                  ent_idx        <= chk_idx;
                  blk            <= rd_blk;
                  state          <= S_DEL;
                end
              endcase
            end else if (last_ent) begin
              res_idx <= '0;
              res_blk <= '0;
              case (op)
                fita_pkg::MODE_CREATE: begin
                  if (free_found || !chk_ent_v) begin
                    ent_idx <= free_found ? free_idx : chk_idx;
                    w_cnt   <= '0;
                    chk_vld <= 1'b0;
                    state   <= S_BSCAN;
                  end else begin
                    res_status <= fita_pkg::ST_NO_ENTRY;
                    state      <= S_DONE;
                  end
                end
                default: begin
                  res_status <= fita_pkg::ST_NOT_FOUND;
                  state      <= S_DONE;
                end
              endcase
            end
          end
        end

        S_DEL: begin
          res_status <= fita_pkg::ST_OK;
          res_idx    <= ent_idx;
          res_blk    <= blk;
          state      <= S_DONE;
        end

        S_BSCAN: begin
          chk_vld <= 1'b1;
          chk_w   <= w_cnt;
          if (w_cnt != WW'(WORDS - 1)) begin
            w_cnt <= w_cnt + WW'(1);
          end
          if (chk_vld) begin
            if (word_free) begin
              valid[ent_idx] <= 1'b1;
              res_status     <= fita_pkg::ST_OK;
              res_idx        <= ent_idx;
              res_blk        <= new_blk;
              state          <= S_DONE;
            end else if (last_word) begin
              res_status <= fita_pkg::ST_NO_BLOCK;
              res_idx    <= '0;
              res_blk    <= '0;
              state      <= S_DONE;
            end
          end
        end

        S_DONE: begin
          // hold until the response register is free
          if (!rsp_valid || rsp_ready) begin
            rsp_valid   <= 1'b1;
            status      <= res_status;
            entry_index <= idx_wide[fita_pkg::INDEX_W-1:0];
            disk_block  <= blk_wide[fita_pkg::BLOCK_W-1:0];
            state       <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/fita_ram.sv
// ----------------------------------------------------------------------------
// fita_ram: generic synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fita_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/fita_checker.sv
// ----------------------------------------------------------------------------
// fita_checker: port-level checks of the file entry table allocator
// Watches the request and response channels; attached to the top by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module fita_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            req_valid,
  input wire logic                            req_ready,
  input wire logic                            rsp_valid,
  input wire logic                            rsp_ready,
  input wire logic [fita_pkg::STATUS_W-1:0]   status,
  input wire logic [fita_pkg::INDEX_W-1:0]    entry_index,
  input wire logic [fita_pkg::BLOCK_W-1:0]    disk_block
);

  // a stalled response holds its item
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
      $stable(entry_index) && $stable(disk_block))
    else $error("response item changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status == fita_pkg::ST_OK || status == fita_pkg::ST_EXISTS ||
      status == fita_pkg::ST_NOT_FOUND || status == fita_pkg::ST_NO_ENTRY ||
      status == fita_pkg::ST_NO_BLOCK)
    else $error("undefined status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != fita_pkg::ST_OK |-> entry_index == '0 && disk_block == '0)
    else $error("failed request returned a non-zero index or block");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in work");

endmodule

bind file_inode_table_allocator_unit fita_checker u_fita_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req_valid),
  .req_ready    (req_ready),
  .rsp_valid    (rsp_valid),
  .rsp_ready    (rsp_ready),
  .status       (status),
  .entry_index  (entry_index),
  .disk_block   (disk_block)
);

`default_nettype wire
